@@ rtl/core/odo_pkg.sv @@
// Shared types, constants and codes for the wheel encoder odometry block.
package odo_pkg;

  localparam int COUNT_BITS = 16;
  localparam int VAL_BITS   = 32;
  localparam int NUM_WHEELS = 4;
  localparam int GAIN_BITS  = 32;
  localparam int RAD_BITS   = 16;
  localparam int PER_BITS   = 24;
  localparam int ADDR_BITS  = 4;
  localparam int DIV_STEPS  = 2;
  localparam int DCNT_BITS  = $clog2(DIV_STEPS);

  localparam logic [63:0] RAW_CLAMP = 64'h1000_0000_0000_0000;
  localparam logic [63:0] DIV_LIMIT = 64'h0000_0002_8000_0000;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [1:0] REG_RATE_GAIN     = 2'd0;
  localparam logic [1:0] REG_WHEEL_RADIUS  = 2'd1;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

  localparam int LANE_LF = 0;
  localparam int LANE_LR = 1;
  localparam int LANE_RF = 2;
  localparam int LANE_RR = 3;

  typedef struct packed {
    logic                          kind;
    logic signed [COUNT_BITS-1:0]  count_left_front;
    logic signed [COUNT_BITS-1:0]  count_left_rear;
    logic signed [COUNT_BITS-1:0]  count_right_front;
    logic signed [COUNT_BITS-1:0]  count_right_rear;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_BITS-1:0] rate_left_front;
    logic signed [VAL_BITS-1:0] rate_left_rear;
    logic signed [VAL_BITS-1:0] rate_right_front;
    logic signed [VAL_BITS-1:0] rate_right_rear;
    logic signed [VAL_BITS-1:0] speed_left_front;
    logic signed [VAL_BITS-1:0] speed_left_rear;
    logic signed [VAL_BITS-1:0] speed_right_front;
    logic signed [VAL_BITS-1:0] speed_right_rear;
    logic signed [VAL_BITS-1:0] total_length;
    logic signed [VAL_BITS-1:0] delta_length;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic prep_en;
    logic div_en;
    logic rate_en;
    logic smul_en;
    logic speed_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic dmul_en;
    logic dist_en;
    logic len_en;
    logic clear;
  } merge_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_RATE,
    ST_SMUL,
    ST_SPEED,
    ST_DMUL,
    ST_DIST,
    ST_LEN,
    ST_OUT
  } state_t;

endpackage

@@ rtl/core/odo_lane.sv @@
// One wheel lane: count scaling, smoothing filter with divide by five, and speed.
module odo_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  odo_pkg::lane_ctrl_t                   ctrl,
  input  logic signed [odo_pkg::COUNT_BITS-1:0] count,
  input  logic [odo_pkg::GAIN_BITS-1:0]         rate_gain,
  input  logic [odo_pkg::RAD_BITS-1:0]          wheel_radius,
  output logic signed [odo_pkg::VAL_BITS-1:0]   rate,
  output logic signed [odo_pkg::VAL_BITS-1:0]   speed
);

  localparam int CB       = odo_pkg::COUNT_BITS;
  localparam int MAG_BITS = CB + odo_pkg::GAIN_BITS;
  localparam int SP_BITS  = odo_pkg::VAL_BITS + odo_pkg::RAD_BITS + 1;

  // Reciprocal of five scaled by 2^36 and rounded up; exact for dividends below 2^34.
  localparam logic [33:0] RECIP_FIVE = 34'h3_3333_3334;

  logic [CB-1:0]       cnt_bits;
  logic [CB-1:0]       cnt_mag;
  logic [MAG_BITS-1:0] mag_nxt;
  logic [MAG_BITS-1:0] mag_r;
  logic                cneg_r;

  logic [63:0]         raw_mag;
  logic signed [63:0]  raw;
  logic signed [63:0]  old_x4;
  logic signed [63:0]  acc;
  logic [63:0]         acc_mag;
  logic [63:0]         dividend;

  logic [33:0]         dq_r;
  logic [51:0]         dsum_r;
  logic [50:0]         dpart;
  logic [51:0]         dsum_nxt;
  logic [31:0]         quot;
  logic                xneg_r;
  logic                big_r;

  logic signed [odo_pkg::VAL_BITS-1:0] rate_r;
  logic signed [odo_pkg::VAL_BITS-1:0] rate_nxt;

  logic signed [SP_BITS-1:0] sprod_nxt;
  logic signed [SP_BITS-1:0] sprod_r;
  logic [SP_BITS-1:0]        smag;
  logic [SP_BITS-1:0]        smag_rnd;
  logic [31:0]               sres;
  logic signed [odo_pkg::VAL_BITS-1:0] speed_r;

  assign cnt_bits = count;
  assign cnt_mag  = cnt_bits[CB-1] ? (~cnt_bits + 1'b1) : cnt_bits;
  assign mag_nxt  = MAG_BITS'(cnt_mag) * MAG_BITS'(rate_gain);

  always_comb begin
    raw_mag = 64'(mag_r);
    if (raw_mag > odo_pkg::RAW_CLAMP) begin
      raw_mag = odo_pkg::RAW_CLAMP;
    end
    raw      = cneg_r ? -$signed(raw_mag) : $signed(raw_mag);
    old_x4   = 64'(rate_r) <<< 2;
    acc      = raw + old_x4;
    acc_mag  = acc[63] ? (64'd0 - $unsigned(acc)) : $unsigned(acc);
    dividend = acc_mag + 64'd2;
  end

  // The dividend is multiplied by the reciprocal 17 bits at a time, low half first.
  assign dpart    = 51'(dq_r[16:0]) * 51'(RECIP_FIVE);
  assign dsum_nxt = 52'(dsum_r[51:17]) + 52'(dpart);
  assign quot     = dsum_r[50:19];

  always_comb begin
    if (big_r) begin
      rate_nxt = xneg_r ? {1'b1, {(odo_pkg::VAL_BITS-1){1'b0}}}
                        : {1'b0, {(odo_pkg::VAL_BITS-1){1'b1}}};
    end else if (xneg_r) begin
      rate_nxt = $signed(32'd0 - quot);
    end else begin
      rate_nxt = $signed(quot);
    end
  end

  assign sprod_nxt = SP_BITS'(rate_r) * SP_BITS'($signed({1'b0, wheel_radius}));
  assign smag      = sprod_r[SP_BITS-1] ? (SP_BITS'(0) - $unsigned(sprod_r))
                                        : $unsigned(sprod_r);
  assign smag_rnd  = smag + SP_BITS'(32768);
  assign sres      = smag_rnd[47:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
    end else if (ctrl.rate_en) begin
      rate_r <= rate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      mag_r  <= mag_nxt;
      cneg_r <= cnt_bits[CB-1];
    end
    if (ctrl.prep_en) begin
      xneg_r <= acc[63];
      big_r  <= (dividend >= odo_pkg::DIV_LIMIT);
      dq_r   <= dividend[33:0];
      dsum_r <= '0;
    end else if (ctrl.div_en) begin
      dq_r   <= {17'd0, dq_r[33:17]};
      dsum_r <= dsum_nxt;
    end
    if (ctrl.smul_en) begin
      sprod_r <= sprod_nxt;
    end
    if (ctrl.speed_en) begin
      speed_r <= sprod_r[SP_BITS-1] ? $signed(32'd0 - sres) : $signed(sres);
    end
  end

  assign rate  = rate_r;
  assign speed = speed_r;

endmodule

@@ rtl/core/odo_merge.sv @@
// Merging stage: distance integration for two wheels and the length outputs.
module odo_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  odo_pkg::merge_ctrl_t                ctrl,
  input  logic signed [odo_pkg::VAL_BITS-1:0] speed_lf,
  input  logic signed [odo_pkg::VAL_BITS-1:0] speed_rr,
  input  logic [odo_pkg::PER_BITS-1:0]        sample_period,
  output logic signed [odo_pkg::VAL_BITS-1:0] total_length,
  output logic signed [odo_pkg::VAL_BITS-1:0] delta_length
);

  localparam int DP_BITS = odo_pkg::VAL_BITS + odo_pkg::PER_BITS + 1;

  logic signed [odo_pkg::VAL_BITS-1:0] speed_in [2];
  logic signed [DP_BITS-1:0]           dprod_r  [2];
  logic signed [odo_pkg::VAL_BITS-1:0] dist_r   [2];
  logic signed [odo_pkg::VAL_BITS-1:0] dist_nxt [2];
  logic signed [odo_pkg::VAL_BITS-1:0] total_r;
  logic signed [odo_pkg::VAL_BITS-1:0] delta_r;
  logic signed [32:0]                  len_sum;
  logic signed [32:0]                  len_diff;

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] d,
                                                 input logic signed [DP_BITS-1:0] p);
    logic [DP_BITS-1:0] pm;
    logic [DP_BITS-1:0] pr;
    logic [31:0]        incm;
    logic signed [33:0] inc;
    logic signed [33:0] s;
    pm   = p[DP_BITS-1] ? (DP_BITS'(0) - $unsigned(p)) : $unsigned(p);
    pr   = pm + DP_BITS'(24'h80_0000);
    incm = pr[55:24];
    inc  = p[DP_BITS-1] ? -$signed({2'b00, incm}) : $signed({2'b00, incm});
    s    = 34'(d) + inc;
    if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
      add_sat = s[31:0];
    end else if (s[33]) begin
      add_sat = {1'b1, 31'd0};
    end else begin
      add_sat = {1'b0, {31{1'b1}}};
    end
  endfunction

  function automatic logic signed [31:0] half_round(input logic signed [32:0] v);
    logic [32:0] m;
    logic [32:0] h;
    m = v[32] ? (33'd0 - $unsigned(v)) : $unsigned(v);
    h = (m + 33'd1) >> 1;
    if (!v[32] && h[31]) begin
      half_round = {1'b0, {31{1'b1}}};
    end else if (v[32]) begin
      half_round = $signed(32'd0 - h[31:0]);
    end else begin
      half_round = $signed(h[31:0]);
    end
  endfunction

  assign speed_in[0] = speed_lf;
  assign speed_in[1] = speed_rr;

  for (genvar g = 0; g < 2; g++) begin : g_wheel
    assign dist_nxt[g] = ctrl.clear ? '0 : add_sat(dist_r[g], dprod_r[g]);

    always_ff @(posedge clk) begin
      if (ctrl.dmul_en) begin
        dprod_r[g] <= DP_BITS'(speed_in[g]) * DP_BITS'($signed({1'b0, sample_period}));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dist_r[g] <= '0;
      end else if (ctrl.dist_en) begin
        dist_r[g] <= dist_nxt[g];
      end
    end
  end

  assign len_sum  = 33'(dist_r[0]) + 33'(dist_r[1]);
  assign len_diff = 33'(dist_r[0]) - 33'(dist_r[1]);

  always_ff @(posedge clk) begin
    if (ctrl.len_en) begin
      total_r <= half_round(len_sum);
      delta_r <= half_round(len_diff);
    end
  end

  assign total_length = total_r;
  assign delta_length = delta_r;

endmodule

@@ rtl/core/four_wheel_encoder_odometry.sv @@
// Top level of the four wheel encoder odometry block: sequencer, registers and lanes.
// A sample tick item runs the lane steps (multiply, prepare, a two-step reciprocal
// multiply for the divide by five, rate, speed multiply, speed), the merge steps (distance
// multiply, distance, length) and the output step; a clear item starts at the speed
// multiply. A result waits in the output register while the next item is processed.
// Synchronous active-low reset zeroes the rates, distances, registers and output valid.
module four_wheel_encoder_odometry (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  odo_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output odo_pkg::out_item_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [odo_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  odo_pkg::state_t   state_r;
  odo_pkg::state_t   state_nxt;
  logic [odo_pkg::DCNT_BITS-1:0] div_cnt_r;
  logic [odo_pkg::DCNT_BITS-1:0] div_cnt_nxt;
  odo_pkg::in_item_t item_r;
  odo_pkg::out_item_t out_data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              slot_free;
  logic              in_take;
  logic              cfg_write;
  logic [1:0]        reg_idx;

  logic [odo_pkg::GAIN_BITS-1:0] rate_gain_r;
  logic [odo_pkg::RAD_BITS-1:0]  wheel_radius_r;
  logic [odo_pkg::PER_BITS-1:0]  sample_period_r;

  odo_pkg::lane_ctrl_t  lane_ctrl;
  odo_pkg::merge_ctrl_t merge_ctrl;

  logic signed [odo_pkg::COUNT_BITS-1:0] counts [odo_pkg::NUM_WHEELS];
  logic signed [odo_pkg::VAL_BITS-1:0]   rates  [odo_pkg::NUM_WHEELS];
  logic signed [odo_pkg::VAL_BITS-1:0]   speeds [odo_pkg::NUM_WHEELS];
  logic signed [odo_pkg::VAL_BITS-1:0]   total_length;
  logic signed [odo_pkg::VAL_BITS-1:0]   delta_length;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_gain_r     <= '0;
      wheel_radius_r  <= '0;
      sample_period_r <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        odo_pkg::REG_RATE_GAIN:     rate_gain_r     <= pwdata;
        odo_pkg::REG_WHEEL_RADIUS:  wheel_radius_r  <= pwdata[odo_pkg::RAD_BITS-1:0];
        odo_pkg::REG_SAMPLE_PERIOD: sample_period_r <= pwdata[odo_pkg::PER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      odo_pkg::REG_RATE_GAIN:     prdata = rate_gain_r;
      odo_pkg::REG_WHEEL_RADIUS:  prdata = 32'(wheel_radius_r);
      odo_pkg::REG_SAMPLE_PERIOD: prdata = 32'(sample_period_r);
      default:                    prdata = '0;
    endcase
  end

  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = '0;
    unique case (state_r)
      odo_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = (in_data.kind == odo_pkg::KIND_CLEAR) ? odo_pkg::ST_SMUL
                                                           : odo_pkg::ST_MUL;
        end
      end
      odo_pkg::ST_MUL:   state_nxt = odo_pkg::ST_PREP;
      odo_pkg::ST_PREP:  state_nxt = odo_pkg::ST_DIV;
      odo_pkg::ST_DIV: begin
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == odo_pkg::DCNT_BITS'(odo_pkg::DIV_STEPS - 1)) begin
          state_nxt = odo_pkg::ST_RATE;
        end
      end
      odo_pkg::ST_RATE:  state_nxt = odo_pkg::ST_SMUL;
      odo_pkg::ST_SMUL:  state_nxt = odo_pkg::ST_SPEED;
      odo_pkg::ST_SPEED: state_nxt = odo_pkg::ST_DMUL;
      odo_pkg::ST_DMUL:  state_nxt = odo_pkg::ST_DIST;
      odo_pkg::ST_DIST:  state_nxt = odo_pkg::ST_LEN;
      odo_pkg::ST_LEN:   state_nxt = odo_pkg::ST_OUT;
      odo_pkg::ST_OUT: begin
        if (slot_free) begin
          state_nxt = odo_pkg::ST_IDLE;
        end
      end
      default:           state_nxt = odo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall           = (state_r != odo_pkg::ST_IDLE);
    lane_ctrl          = '0;
    merge_ctrl         = '0;
    merge_ctrl.clear   = (item_r.kind == odo_pkg::KIND_CLEAR);
    out_valid_nxt      = out_valid_r && out_stall;
    unique case (state_r)
      odo_pkg::ST_MUL:   lane_ctrl.mul_en   = 1'b1;
      odo_pkg::ST_PREP:  lane_ctrl.prep_en  = 1'b1;
      odo_pkg::ST_DIV:   lane_ctrl.div_en   = 1'b1;
      odo_pkg::ST_RATE:  lane_ctrl.rate_en  = 1'b1;
      odo_pkg::ST_SMUL:  lane_ctrl.smul_en  = 1'b1;
      odo_pkg::ST_SPEED: lane_ctrl.speed_en = 1'b1;
      odo_pkg::ST_DMUL:  merge_ctrl.dmul_en = 1'b1;
      odo_pkg::ST_DIST:  merge_ctrl.dist_en = 1'b1;
      odo_pkg::ST_LEN:   merge_ctrl.len_en  = 1'b1;
      odo_pkg::ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= odo_pkg::ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_data;
    end
    if (state_r == odo_pkg::ST_OUT && slot_free) begin
      out_data_r.rate_left_front   <= rates[odo_pkg::LANE_LF];
      out_data_r.rate_left_rear    <= rates[odo_pkg::LANE_LR];
      out_data_r.rate_right_front  <= rates[odo_pkg::LANE_RF];
      out_data_r.rate_right_rear   <= rates[odo_pkg::LANE_RR];
      out_data_r.speed_left_front  <= speeds[odo_pkg::LANE_LF];
      out_data_r.speed_left_rear   <= speeds[odo_pkg::LANE_LR];
      out_data_r.speed_right_front <= speeds[odo_pkg::LANE_RF];
      out_data_r.speed_right_rear  <= speeds[odo_pkg::LANE_RR];
      out_data_r.total_length      <= total_length;
      out_data_r.delta_length      <= delta_length;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign counts[odo_pkg::LANE_LF] = item_r.count_left_front;
  assign counts[odo_pkg::LANE_LR] = item_r.count_left_rear;
  assign counts[odo_pkg::LANE_RF] = item_r.count_right_front;
  assign counts[odo_pkg::LANE_RR] = item_r.count_right_rear;

  for (genvar g = 0; g < odo_pkg::NUM_WHEELS; g++) begin : g_lane
    odo_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (lane_ctrl),
      .count        (counts[g]),
      .rate_gain    (rate_gain_r),
      .wheel_radius (wheel_radius_r),
      .rate         (rates[g]),
      .speed        (speeds[g])
    );
  end

  odo_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (merge_ctrl),
    .speed_lf      (speeds[odo_pkg::LANE_LF]),
    .speed_rr      (speeds[odo_pkg::LANE_RR]),
    .sample_period (sample_period_r),
    .total_length  (total_length),
    .delta_length  (delta_length)
  );

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r != odo_pkg::ST_IDLE)
    else $error("Accepted item did not start the sequencer.");

  a_rose_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == odo_pkg::ST_OUT))
    else $error("Result appeared without passing the output state.");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == odo_pkg::ST_DIV &&
     div_cnt_r == odo_pkg::DCNT_BITS'(odo_pkg::DIV_STEPS - 1)) |=> state_r == odo_pkg::ST_RATE)
    else $error("Divider did not finish after its last step.");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == odo_pkg::ST_OUT && slot_free && item_r.kind == odo_pkg::KIND_CLEAR)
    |=> (out_data_r.total_length == '0 && out_data_r.delta_length == '0))
    else $error("Clear item gave non-zero lengths.");

endmodule
